[hdl/systematic_resampler_top_macros.svh]
// ----------------------------------------------------------------------------
// Systematic resampler assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYSTEMATIC_RESAMPLER_TOP_MACROS_SVH
`define SYSTEMATIC_RESAMPLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// hold a property at every edge outside reset
`define SR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define SR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SR_ASSERT(lbl, prop, msg)
`define SR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/rsmp_pkg.sv]
// ----------------------------------------------------------------------------
// Systematic resampler package
// Opcodes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmp_pkg;

	localparam int PIN_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int OFFSET_W    = 32;
	localparam int STEP_W      = 32;
	localparam int INDEX_OUT_W = 6;
	localparam int MIN_PARTICLES = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PARTICLES_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_INCREMENT   = 1'b1;

	localparam logic [PIN_W-1:0]  PIN_RESET  = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET = 32'd67108864;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_PRIME,
		WK_STEP
	} walk_state_t;

	typedef struct packed {
		logic busy;
		logic rd_en;
	} walk_stat_t;

endpackage

`default_nettype wire

[hdl/rsmp_wmem.sv]
// ----------------------------------------------------------------------------
// Weight memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_wmem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/rsmp_walk.sv]
// ----------------------------------------------------------------------------
// Resampling walk engine
// Walks the weight memory once per round and emits one index per pointer slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_walk #(
	parameter int MAX_PARTICLES = 64,
	parameter int WEIGHT_BITS   = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [rsmp_pkg::OFFSET_W-1:0]        offset,
	input  wire logic [$clog2(MAX_PARTICLES+1)-1:0]   count,
	input  wire logic [rsmp_pkg::STEP_W-1:0]          step,
	input  wire logic [WEIGHT_BITS-1:0]               rdata,
	output rsmp_pkg::walk_stat_t                      stat,
	output logic      [$clog2(MAX_PARTICLES)-1:0]     rd_addr,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [rsmp_pkg::INDEX_OUT_W-1:0]     selected_index,
	output logic                                      last_of_round
);

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES+1);
	localparam int P_W   = CNT_W + 1;
	localparam int ACC_W = WEIGHT_BITS + 1;
	localparam int SUM_W = ((ACC_W > rsmp_pkg::STEP_W) ? ACC_W : rsmp_pkg::STEP_W) + 1;
	localparam int OUT_W = rsmp_pkg::INDEX_OUT_W;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
	                                             input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + b;
		return (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
	endfunction

	rsmp_pkg::walk_state_t state_q, state_d;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] slot_q;
	logic [ACC_W-1:0] cum_q;
	logic [ACC_W-1:0] ptr_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic             out_last_q;

	logic [P_W-1:0]   idx_p1;
	logic [P_W-1:0]   idx_p2;
	logic [P_W-1:0]   count_p;
	logic [SUM_W-1:0] offset_ext;
	logic             advance;
	logic             slot_last;
	logic             emit_ok;
	logic             adv_go;
	logic             emit_go;

	assign idx_p1     = P_W'(idx_q) + P_W'(1);
	assign idx_p2     = P_W'(idx_q) + P_W'(2);
	assign count_p    = P_W'(count);
	assign offset_ext = SUM_W'(offset);
	assign advance    = (ptr_q > cum_q) && (idx_p1 < count_p);
	assign slot_last  = (P_W'(slot_q) + P_W'(1)) == count_p;
	assign emit_ok    = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rsmp_pkg::WK_IDLE: begin
				if (start) begin
					state_d = rsmp_pkg::WK_PRIME;
				end
			end
			rsmp_pkg::WK_PRIME: begin
				state_d = rsmp_pkg::WK_STEP;
			end
			rsmp_pkg::WK_STEP: begin
				if (!advance && emit_ok && slot_last) begin
					state_d = rsmp_pkg::WK_IDLE;
				end
			end
			default: begin
				state_d = rsmp_pkg::WK_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.busy  = 1'b1;
		stat.rd_en = 1'b0;
		rd_addr    = '0;
		adv_go     = 1'b0;
		emit_go    = 1'b0;
		case (state_q)
			rsmp_pkg::WK_IDLE: begin
				stat.busy  = 1'b0;
				stat.rd_en = start;
			end
			rsmp_pkg::WK_PRIME: begin
				stat.rd_en = 1'b1;
				rd_addr    = IDX_W'(1);
			end
			rsmp_pkg::WK_STEP: begin
				adv_go     = advance;
				emit_go    = !advance && emit_ok;
				// prefetch the weight after the one being added
				stat.rd_en = advance && (idx_p2 < count_p);
				rd_addr    = idx_p2[IDX_W-1:0];
			end
			default: begin
				stat.busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsmp_pkg::WK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsmp_pkg::WK_IDLE && start) begin
			idx_q  <= '0;
			slot_q <= '0;
			ptr_q  <= (offset_ext > SUM_W'(ACC_MAX)) ? ACC_MAX : offset_ext[ACC_W-1:0];
		end
		if (state_q == rsmp_pkg::WK_PRIME) begin
			cum_q <= ACC_W'(rdata);
		end
		if (adv_go) begin
			idx_q <= idx_p1[IDX_W-1:0];
			cum_q <= sat_add(cum_q, SUM_W'(rdata));
		end
		if (emit_go) begin
			out_index_q <= idx_q;
			out_last_q  <= slot_last;
			if (!slot_last) begin
				ptr_q  <= sat_add(ptr_q, SUM_W'(step));
				slot_q <= slot_q + IDX_W'(1);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = OUT_W'(out_index_q);
	assign last_of_round  = out_last_q;

endmodule

`default_nettype wire

[hdl/systematic_resampler_top.sv]
// ----------------------------------------------------------------------------
// Systematic resampler
// Particle weight store and systematic resampling walk.
// ----------------------------------------------------------------------------
// Load transfers (opcode 0) write the next weight entry; loads beyond the
// clamped particles_in_use count are dropped. A start transfer (opcode 1)
// runs one round that yields that clamped count of index transfers. The
// weight memory's single read port delivers one entry per cycle to the
// accumulate-and-compare loop while the walk advances past store entries.
// Input is not taken while a round runs. The last index can wait in the
// output register while new loads are taken. Weight entries are not cleared
// at reset and must be loaded before a round reads them.
`default_nettype none
`include "systematic_resampler_top_macros.svh"

module systematic_resampler_top #(
	parameter int MAX_PARTICLES = 64,
	parameter int WEIGHT_BITS   = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [rsmp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rsmp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                opcode,
	input  wire logic [31:0]                         weight_value,
	input  wire logic [rsmp_pkg::OFFSET_W-1:0]       random_offset,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [rsmp_pkg::INDEX_OUT_W-1:0]    selected_index,
	output logic                                     last_of_round
);

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES+1);
	localparam int PIN_W = rsmp_pkg::PIN_W;

	logic [PIN_W-1:0]              pin_q;
	logic [rsmp_pkg::STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]              load_count_q;
	logic [CNT_W-1:0]              count;
	logic                          in_xfer;
	logic                          start;
	logic                          mem_we;
	logic [WEIGHT_BITS-1:0]        mem_rdata;
	logic [IDX_W-1:0]              rd_addr;
	rsmp_pkg::walk_stat_t          walk_stat;

	// clamp the particle count into the supported range
	always_comb begin
		if (pin_q < PIN_W'(rsmp_pkg::MIN_PARTICLES)) begin
			count = CNT_W'(rsmp_pkg::MIN_PARTICLES);
		end else if (pin_q > PIN_W'(MAX_PARTICLES)) begin
			count = CNT_W'(MAX_PARTICLES);
		end else begin
			count = CNT_W'(pin_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q  <= rsmp_pkg::PIN_RESET;
			step_q <= rsmp_pkg::STEP_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				rsmp_pkg::CFG_PARTICLES_IN_USE: pin_q  <= cfg_data[PIN_W-1:0];
				rsmp_pkg::CFG_STEP_INCREMENT:   step_q <= cfg_data[rsmp_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !walk_stat.busy;
	assign in_xfer  = in_valid && in_ready;
	assign start    = in_xfer && (opcode == rsmp_pkg::OP_START);
	assign mem_we   = in_xfer && (opcode == rsmp_pkg::OP_LOAD) && (load_count_q < count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (start) begin
			load_count_q <= '0;
		end else if (mem_we) begin
			load_count_q <= load_count_q + CNT_W'(1);
		end
	end

	rsmp_wmem #(
		.DEPTH (MAX_PARTICLES),
		.WIDTH (WEIGHT_BITS)
	) u_wmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (load_count_q[IDX_W-1:0]),
		.wdata (WEIGHT_BITS'(weight_value)),
		.re    (walk_stat.rd_en),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	rsmp_walk #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.WEIGHT_BITS   (WEIGHT_BITS)
	) u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.offset         (random_offset),
		.count          (count),
		.step           (step_q),
		.rdata          (mem_rdata),
		.stat           (walk_stat),
		.rd_addr        (rd_addr),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.selected_index (selected_index),
		.last_of_round  (last_of_round)
	);

	`SR_ASSERT(a_no_write_in_round, walk_stat.busy |-> !mem_we, "weight write during a round")
	`SR_ASSERT_NEXT(a_prime_read, start, walk_stat.busy && walk_stat.rd_en, "no prime read after start")
	`SR_ASSERT(a_index_in_range, out_valid |-> (selected_index < count), "index beyond particle count")

endmodule

`default_nettype wire

[tb/tb_systematic_resampler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systematic resampler testbench
// Loads particle weights, starts resampling rounds and compares every index
// transfer against a bit-accurate predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_systematic_resampler_top;

	localparam int NUM_SLOTS      = 64;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 430;

	typedef struct packed {
		logic [rsmp_pkg::INDEX_OUT_W-1:0] idx;
		logic                             last;
	} pick_t;

	class resample_scoreboard;
		logic [31:0]                 weights [NUM_SLOTS];
		bit                          written [NUM_SLOTS];
		int unsigned                 load_cnt;
		logic [rsmp_pkg::PIN_W-1:0]  pin_reg;
		logic [rsmp_pkg::STEP_W-1:0] step_reg;
		pick_t                       expected_picks [$];
		int unsigned                 mismatches;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				weights[i] = '0;
				written[i] = 1'b0;
			end
			load_cnt = 0;
			pin_reg = rsmp_pkg::PIN_RESET;
			step_reg = rsmp_pkg::STEP_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [rsmp_pkg::CFG_IDX_W-1:0] sel,
		                        logic [rsmp_pkg::CFG_DATA_W-1:0] data);
			if (sel == rsmp_pkg::CFG_PARTICLES_IN_USE) begin
				pin_reg = data[rsmp_pkg::PIN_W-1:0];
			end else begin
				step_reg = data[rsmp_pkg::STEP_W-1:0];
			end
		endfunction

		function int unsigned active_count();
			if (pin_reg < rsmp_pkg::MIN_PARTICLES) begin
				return rsmp_pkg::MIN_PARTICLES;
			end
			if (pin_reg > NUM_SLOTS) begin
				return NUM_SLOTS;
			end
			return pin_reg;
		endfunction

		function bit entries_written(int unsigned from_idx, int unsigned upto);
			for (int unsigned i = from_idx; i < upto; i++) begin
				if (!written[i]) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function logic [32:0] sat_add33(logic [32:0] a, logic [32:0] b);
			logic [33:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[33] ? {33{1'b1}} : s[32:0];
		endfunction

		// Predict the index transfers caused by one accepted input transfer.
		function void note_input(logic op, logic [31:0] w, logic [31:0] off);
			int unsigned n;
			int unsigned pick;
			logic [32:0] cum;
			logic [32:0] ptr;
			pick_t p;
			n = active_count();
			if (op == rsmp_pkg::OP_LOAD) begin
				// drop loads past the round size
				if (load_cnt < n) begin
					weights[load_cnt] = w;
					written[load_cnt] = 1'b1;
					load_cnt++;
				end
				return;
			end
			load_cnt = 0;
			pick = 0;
			cum = {1'b0, weights[0]};
			ptr = {1'b0, off};
			for (int unsigned slot = 0; slot < n; slot++) begin
				while (ptr > cum && pick + 1 < n) begin
					pick++;
					cum = sat_add33(cum, {1'b0, weights[pick]});
				end
				p.idx = pick[rsmp_pkg::INDEX_OUT_W-1:0];
				p.last = (slot + 1 == n);
				expected_picks.push_back(p);
				if (slot + 1 < n) begin
					ptr = sat_add33(ptr, {1'b0, step_reg});
				end
			end
		endfunction

		function void check_result(logic [rsmp_pkg::INDEX_OUT_W-1:0] got_idx, logic got_last);
			pick_t p;
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected index transfer: index %0d last %0b", got_idx, got_last);
				end
				return;
			end
			p = expected_picks.pop_front();
			if (p.idx !== got_idx || p.last !== got_last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected index %0d last %0b, got index %0d last %0b",
						p.idx, p.last, got_idx, got_last);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_picks.size();
		endfunction

		function bit failed();
			return (mismatches != 0) || (expected_picks.size() != 0);
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_write_en;
	logic [rsmp_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [rsmp_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic                             opcode;
	logic [31:0]                      weight_value;
	logic [rsmp_pkg::OFFSET_W-1:0]    random_offset;
	logic                             out_valid;
	logic                             out_ready;
	logic [rsmp_pkg::INDEX_OUT_W-1:0] selected_index;
	logic                             last_of_round;

	resample_scoreboard sb;
	bit                 hold_off_req;
	int unsigned        send_quiet;
	int unsigned        recv_quiet;
	int unsigned        idle_cycles;

	systematic_resampler_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.weight_value   (weight_value),
		.random_offset  (random_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.selected_index (selected_index),
		.last_of_round  (last_of_round)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Draws a random idle gap before each transfer, with occasional runs of back-to-back transfers.
	function automatic int unsigned draw_gap(inout int unsigned quiet);
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(8, 32);
		end
		return $urandom_range(0, 3);
	endfunction

	// Called and returns at a falling edge; valid stays high between back-to-back items.
	task automatic send_item(input logic op, input logic [31:0] w, input logic [31:0] off);
		int unsigned gap;
		gap = draw_gap(send_quiet);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		weight_value = w;
		random_offset = off;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, w, off);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [rsmp_pkg::CFG_IDX_W-1:0] sel,
	                         input logic [rsmp_pkg::CFG_DATA_W-1:0] data);
		cfg_write_en = 1'b1;
		cfg_index = sel;
		cfg_data = data;
		sb.write_reg(sel, data);
		@(negedge clk);
		cfg_write_en = 1'b0;
	endtask

	// Hold input until every index transfer is back, then let trailing loads settle.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : receiver
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			gap = draw_gap(recv_quiet);
			if (gap != 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(selected_index, last_of_round);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("** systematic_resampler_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned phase;
		int unsigned rounds;
		int unsigned cnt;
		int unsigned nloads;
		int unsigned k;
		logic [6:0]  pin;
		logic [32:0] full_share;
		logic [31:0] share;
		logic [31:0] step;
		logic [31:0] w;
		logic [31:0] off;
		int unsigned regsel;

		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = rsmp_pkg::OP_LOAD;
		weight_value = '0;
		random_offset = '0;
		hold_off_req = 1'b0;
		send_quiet = 0;
		recv_quiet = 0;
		idle_cycles = 0;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Round size below range acts as two; a third load is dropped.
		write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, 32'd0);
		write_reg(rsmp_pkg::CFG_STEP_INCREMENT, 32'h8000_0000);
		send_item(rsmp_pkg::OP_LOAD, 32'hFFFF_FFFF, $urandom);
		send_item(rsmp_pkg::OP_LOAD, 32'h0000_0000, $urandom);
		send_item(rsmp_pkg::OP_LOAD, 32'h1234_5678, $urandom);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h0000_0000);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h8000_0000);

		// Zero step and zero weights: with a nonzero offset the index must saturate at the last particle.
		wait_idle();
		write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, 32'd1);
		write_reg(rsmp_pkg::CFG_STEP_INCREMENT, 32'd0);
		send_item(rsmp_pkg::OP_LOAD, 32'h0000_0000, $urandom);
		send_item(rsmp_pkg::OP_LOAD, 32'h0000_0000, $urandom);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h8000_0000);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h0000_0000);

		// Partial reload keeps the older entries.
		wait_idle();
		write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, 32'd3);
		write_reg(rsmp_pkg::CFG_STEP_INCREMENT, 32'h5555_5555);
		repeat (3) send_item(rsmp_pkg::OP_LOAD, 32'h5555_5555, $urandom);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h1234_5678);
		send_item(rsmp_pkg::OP_LOAD, 32'hAAAA_AAAA, $urandom);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h0000_0000);

		// Full-scale weights: the cumulative weight grows past 32 bits.
		wait_idle();
		write_reg(rsmp_pkg::CFG_STEP_INCREMENT, 32'h8000_0000);
		repeat (3) send_item(rsmp_pkg::OP_LOAD, 32'hFFFF_FFFF, $urandom);
		send_item(rsmp_pkg::OP_START, $urandom, 32'h8000_0000);

		counted = 0;
		phase = 0;
		while (counted < RANDOM_ITEMS) begin
			wait_idle();
			if (phase == 0) begin
				// above range acts as the full store; the pointer saturates
				write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, 32'd127);
				write_reg(rsmp_pkg::CFG_STEP_INCREMENT, 32'h8000_0000);
			end else if (phase == 1) begin
				write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, 32'd64);
				write_reg(rsmp_pkg::CFG_STEP_INCREMENT, rsmp_pkg::STEP_RESET);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: pin = 7'($urandom_range(2, 12));
					6, 7:             pin = 7'($urandom_range(13, 64));
					8: begin
						case ($urandom_range(0, 3))
							0:       pin = 7'd0;
							1:       pin = 7'd1;
							2:       pin = 7'd65;
							default: pin = 7'($urandom_range(66, 127));
						endcase
					end
					default: pin = 7'd2;
				endcase
				regsel = $urandom_range(0, 3);
				if (regsel != 1) begin
					write_reg(rsmp_pkg::CFG_PARTICLES_IN_USE, {25'd0, pin});
				end
				if (regsel != 0) begin
					full_share = 33'h1_0000_0000 / sb.active_count();
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: step = full_share[31:0];
						6:       step = full_share[31:0] - $urandom_range(0, 255);
						7:       step = $urandom_range(1, 32'h8000_0000);
						8:       step = $urandom_range(0, 1);
						default: step = 32'h8000_0000;
					endcase
					write_reg(rsmp_pkg::CFG_STEP_INCREMENT, step);
				end
			end

			rounds = (phase == 1) ? 3 : $urandom_range(1, 3);
			// long receiver stall while rounds keep coming: fill the block
			if (phase == 1) begin
				hold_off_req = 1'b1;
			end
			for (int unsigned r = 0; r < rounds && counted < RANDOM_ITEMS; r++) begin
				cnt = sb.active_count();
				full_share = 33'h1_0000_0000 / cnt;
				share = full_share[31:0];
				nloads = cnt;
				case ($urandom_range(0, 9))
					0: begin
						k = $urandom_range(0, cnt - 1);
						if (sb.entries_written(k, cnt)) begin
							nloads = k;
						end
					end
					1:       nloads = cnt + $urandom_range(1, 3);
					default: nloads = cnt;
				endcase
				for (int unsigned i = 0; i < nloads; i++) begin
					case ($urandom_range(0, 9))
						0:       w = 32'h0000_0000;
						1:       w = $urandom;
						2:       w = 32'hFFFF_FFFF;
						default: w = $urandom_range(0, share) + $urandom_range(0, share);
					endcase
					send_item(rsmp_pkg::OP_LOAD, w, $urandom);
					if (i < cnt) begin
						counted++;
					end
				end
				if (sb.step_reg != 0 && $urandom_range(0, 9) < 8) begin
					off = $urandom_range(0, sb.step_reg - 1);
				end else begin
					off = $urandom_range(0, 32'h8000_0000);
				end
				send_item(rsmp_pkg::OP_START, $urandom, off);
				counted++;
			end
			phase++;
		end

		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.failed()) begin
			$display("** systematic_resampler_top: FAILED **");
		end else begin
			$display("** systematic_resampler_top: PASSED **");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/rsmp_pkg.sv
hdl/rsmp_wmem.sv
hdl/rsmp_walk.sv
hdl/systematic_resampler_top.sv
tb/tb_systematic_resampler_top.sv
